// File: src/rendezvous_consensus_sequencer_core_assert.svh
// Assertion macros for the rendezvous consensus sequencer.
// Expects signals named clock and reset in the including module.
`ifndef RENDEZVOUS_CONSENSUS_SEQUENCER_CORE_ASSERT_SVH
`define RENDEZVOUS_CONSENSUS_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RCS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RCS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/rcs_pkg.sv
// Shared types, constants and codes of the rendezvous consensus sequencer.
// No dependencies.
package rcs_pkg;

   localparam int MaxAgents = 16;
   localparam int IdxW      = $clog2(MaxAgents);
   localparam int CntW      = $clog2(MaxAgents + 1);

   localparam int AgentW    = 4;
   localparam int OwnW      = 4;
   localparam int CountW    = 5;
   localparam int GainW     = 17;
   localparam int ThrW      = 31;
   localparam int PoseW     = 32;
   localparam int QW        = 34;   // own offset error, current - desired
   localparam int SumW      = 37;   // stored summed error
   localparam int AluW      = 56;   // shared adder and product width
   localparam int FracW     = 16;
   localparam int RoundBias = 32768;

   localparam logic [GainW-1:0] GainOne = 17'd65536;

   localparam logic KIND_TARGET = 1'b0;
   localparam logic KIND_DONE   = 1'b1;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_DESIRED  = 2'd1,
      OP_CURRENT  = 2'd2,
      OP_REACHED  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_OWN       = 2'd0,
      REG_COUNT     = 2'd1,
      REG_GAIN      = 2'd2,
      REG_THRESHOLD = 2'd3
   } reg_idx_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_WAIT  = 3'd1,
      PH_CALC  = 3'd2,
      PH_GOING = 3'd3,
      PH_FINAL = 3'd4
   } phase_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_OWN,
      SEQ_LOOP,
      SEQ_MQ,
      SEQ_SUM,
      SEQ_GAIN,
      SEQ_ROUND,
      SEQ_TGT,
      SEQ_EMIT
   } seq_state_type;

   typedef enum logic [3:0] {
      ALU_NOP,
      ALU_CLEAR,
      ALU_LOAD_OWN,
      ALU_ACC,
      ALU_MUL_MQ,
      ALU_ADD_SUM,
      ALU_MUL_GAIN,
      ALU_ROUND,
      ALU_TARGET
   } alu_op_type;

   typedef struct packed {
      logic                    des_en;
      logic                    cur_en;
      logic [IdxW-1:0]         addr;
      logic signed [PoseW-1:0] pos_z;
      logic signed [PoseW-1:0] pos_x;
   } pose_wr_type;

   typedef struct packed {
      logic signed [PoseW-1:0] des_z;
      logic signed [PoseW-1:0] des_x;
      logic signed [PoseW-1:0] cur_z;
      logic signed [PoseW-1:0] cur_x;
   } pose_rd_type;

   typedef struct packed {
      alu_op_type      op;
      logic [CntW-1:0] m;      // number of other agents summed over
   } alu_ctl_type;

   typedef struct packed {
      logic [OwnW-1:0]   own;
      logic [CountW-1:0] count;
   } seq_cfg_type;

endpackage

// File: src/rcs_pose_store.sv
// Pose memories (desired and current, per agent) and desired-seen flags.
// Depends on rcs_pkg.
module rcs_pose_store
   import rcs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  pose_wr_type          wr,
   input  logic                 clear_seen,
   input  logic                 rd_en,
   input  logic [IdxW-1:0]      rd_addr,
   output pose_rd_type          rd,
   output logic [MaxAgents-1:0] seen
);

   logic [2*PoseW-1:0]   des_mem_ff [MaxAgents];
   logic [2*PoseW-1:0]   cur_mem_ff [MaxAgents];
   logic [2*PoseW-1:0]   des_rd_ff;
   logic [2*PoseW-1:0]   cur_rd_ff;
   logic                 cur_hit_ff;
   logic [MaxAgents-1:0] seen_ff, seen_in;
   logic [MaxAgents-1:0] cur_vld_ff, cur_vld_in;

   always_ff @(posedge clock) begin
      if (wr.des_en) begin
         des_mem_ff[wr.addr] <= {wr.pos_z, wr.pos_x};
      end
      if (wr.cur_en) begin
         cur_mem_ff[wr.addr] <= {wr.pos_z, wr.pos_x};
      end
      if (rd_en) begin
         des_rd_ff  <= des_mem_ff[rd_addr];
         cur_rd_ff  <= cur_mem_ff[rd_addr];
         cur_hit_ff <= cur_vld_ff[rd_addr];
      end
   end

   always_comb begin
      seen_in    = seen_ff;
      cur_vld_in = cur_vld_ff;
      if (clear_seen) begin
         seen_in = '0;
      end
      if (wr.des_en) begin
         seen_in[wr.addr] = 1'b1;
      end
      if (wr.cur_en) begin
         cur_vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         cur_vld_ff <= '0;
      end else begin
         seen_ff    <= seen_in;
         cur_vld_ff <= cur_vld_in;
      end
   end

   // a current pose never written reads as zero
   assign rd.des_z = des_rd_ff[2*PoseW-1:PoseW];
   assign rd.des_x = des_rd_ff[PoseW-1:0];
   assign rd.cur_z = cur_hit_ff ? cur_rd_ff[2*PoseW-1:PoseW] : '0;
   assign rd.cur_x = cur_hit_ff ? cur_rd_ff[PoseW-1:0] : '0;
   assign seen     = seen_ff;

endmodule

// File: src/rcs_axis_unit.sv
// Shared adder and multiplier of one axis, stepped by the sequencer.
// Holds the own offset error, accumulator, product, summed error and target.
// Depends on rcs_pkg.
module rcs_axis_unit
   import rcs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  alu_ctl_type             ctl,
   input  logic [GainW-1:0]        gain_eff,
   input  logic [ThrW-1:0]         threshold,
   input  logic signed [PoseW-1:0] rd_cur,
   input  logic signed [PoseW-1:0] rd_des,
   output logic                    below,
   output logic signed [PoseW-1:0] target
);

   function automatic logic signed [SumW-1:0] sat_sum(input logic signed [AluW-1:0] v);
      logic signed [SumW-1:0] r;
      if (v[AluW-1:SumW-1] == {(AluW-SumW+1){v[AluW-1]}}) begin
         r = v[SumW-1:0];
      end else begin
         r = {v[AluW-1], {(SumW-1){~v[AluW-1]}}};
      end
      return r;
   endfunction

   function automatic logic signed [PoseW-1:0] sat_pose(input logic signed [AluW-1:0] v);
      logic signed [PoseW-1:0] r;
      if (v[AluW-1:PoseW-1] == {(AluW-PoseW+1){v[AluW-1]}}) begin
         r = v[PoseW-1:0];
      end else begin
         r = {v[AluW-1], {(PoseW-1){~v[AluW-1]}}};
      end
      return r;
   endfunction

   logic signed [QW-1:0]    q_ff, q_in;
   logic signed [PoseW-1:0] cur_own_ff, cur_own_in;
   logic signed [AluW-1:0]  acc_ff, acc_in;
   logic signed [AluW-1:0]  prod_ff, prod_in;
   logic signed [SumW-1:0]  sum_ff, sum_in;
   logic signed [PoseW-1:0] tgt_ff, tgt_in;

   logic signed [AluW-1:0]  add_a, add_b, add_c, add_res;
   logic signed [SumW:0]    mul_a;
   logic signed [GainW:0]   mul_b;
   logic signed [AluW-1:0]  mul_res;
   logic [SumW:0]           sum_mag;

   // operand selection for the one adder (a + b - c) and the one multiplier
   always_comb begin
      add_a = '0;
      add_b = '0;
      add_c = '0;
      mul_a = '0;
      mul_b = '0;
      unique case (ctl.op)
         ALU_LOAD_OWN: begin
            add_a = AluW'(rd_cur);
            add_c = AluW'(rd_des);
         end
         ALU_ACC: begin
            add_a = acc_ff;
            add_b = AluW'(rd_des);
            add_c = AluW'(rd_cur);
         end
         ALU_ADD_SUM: begin
            add_a = acc_ff;
            add_b = prod_ff;
         end
         ALU_ROUND: begin
            add_a = prod_ff;
            add_b = AluW'(RoundBias);
         end
         ALU_TARGET: begin
            add_a = AluW'(cur_own_ff);
            add_c = acc_ff;
         end
         ALU_MUL_MQ: begin
            mul_a = (SumW+1)'(q_ff);
            mul_b = {{(GainW+1-CntW){1'b0}}, ctl.m};
         end
         ALU_MUL_GAIN: begin
            mul_a = (SumW+1)'(sum_ff);
            mul_b = {1'b0, gain_eff};
         end
         default: begin
         end
      endcase
   end

   assign add_res = add_a + add_b - add_c;
   assign mul_res = mul_a * mul_b;

   always_comb begin
      q_in       = q_ff;
      cur_own_in = cur_own_ff;
      acc_in     = acc_ff;
      prod_in    = prod_ff;
      sum_in     = sum_ff;
      tgt_in     = tgt_ff;
      unique case (ctl.op)
         ALU_CLEAR:    sum_in = '0;
         ALU_LOAD_OWN: begin
            q_in       = QW'(add_res);
            cur_own_in = rd_cur;
            acc_in     = '0;
         end
         ALU_ACC:      acc_in  = add_res;
         ALU_MUL_MQ:   prod_in = mul_res;
         ALU_ADD_SUM:  sum_in  = sat_sum(add_res);
         ALU_MUL_GAIN: prod_in = mul_res;
         ALU_ROUND:    acc_in  = add_res >>> FracW;   // floor after the half bias
         ALU_TARGET:   tgt_in  = sat_pose(add_res);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff       <= q_in;
      cur_own_ff <= cur_own_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      tgt_ff     <= tgt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign sum_mag = sum_ff[SumW-1] ? ((SumW+1)'(0) - {sum_ff[SumW-1], sum_ff})
                                   : {1'b0, sum_ff};
   assign below   = sum_mag < (SumW+1)'(threshold);
   assign target  = tgt_ff;

endmodule

// File: src/rcs_sequencer.sv
// Phase controller and step sequencer: handles input transactions, walks the
// pose memory through the axis units and owns the result register.
// Depends on rcs_pkg and the assertion macro header.
`include "rendezvous_consensus_sequencer_core_assert.svh"

module rcs_sequencer
   import rcs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  seq_cfg_type             cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_op,
   input  logic [AgentW-1:0]       req_agent,
   input  logic signed [PoseW-1:0] req_pos_z,
   input  logic signed [PoseW-1:0] req_pos_x,
   input  logic                    req_reached,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_kind,
   output logic signed [PoseW-1:0] rsp_target_z,
   output logic signed [PoseW-1:0] rsp_target_x,
   output pose_wr_type             pose_wr,
   output logic                    clear_seen,
   output logic                    rd_en,
   output logic [IdxW-1:0]         rd_addr,
   input  logic [MaxAgents-1:0]    seen,
   output alu_ctl_type             alu_ctl,
   input  logic                    below_z,
   input  logic                    below_x,
   input  logic signed [PoseW-1:0] target_z,
   input  logic signed [PoseW-1:0] target_x
);

   seq_state_type           seq_ff, seq_in;
   phase_type               phase_ff, phase_in;
   logic                    reached_ff, reached_in;
   logic [CntW-1:0]         idx_ff, idx_in;
   logic                    use_ff, use_in;
   logic                    kind_ff, kind_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff;
   logic signed [PoseW-1:0] rsp_z_ff, rsp_x_ff;

   logic [CntW-1:0] n_eff, m_cnt, own_cnt;
   logic            own_in_range, all_seen, agent_ok, accept, load_rsp;

   always_comb begin
      if (cfg.count == '0) begin
         n_eff = CntW'(1);
      end else if (CntW'(cfg.count) > CntW'(MaxAgents)) begin
         n_eff = CntW'(MaxAgents);
      end else begin
         n_eff = CntW'(cfg.count);
      end
   end

   assign own_cnt      = CntW'(cfg.own);
   assign own_in_range = own_cnt < n_eff;
   assign m_cnt        = own_in_range ? n_eff - CntW'(1) : n_eff;
   assign agent_ok     = CntW'(req_agent) < n_eff;
   assign req_ready    = seq_ff == SEQ_IDLE;
   assign accept       = req_valid && req_ready;

   always_comb begin
      all_seen = 1'b1;
      for (int i = 0; i < MaxAgents; i++) begin
         if (CntW'(i) < n_eff && !seen[i]) begin
            all_seen = 1'b0;
         end
      end
   end

   always_comb begin
      seq_in        = seq_ff;
      phase_in      = phase_ff;
      reached_in    = reached_ff;
      idx_in        = idx_ff;
      use_in        = 1'b0;
      kind_in       = kind_ff;
      pose_wr.des_en = 1'b0;
      pose_wr.cur_en = 1'b0;
      pose_wr.addr   = IdxW'(req_agent);
      pose_wr.pos_z  = req_pos_z;
      pose_wr.pos_x  = req_pos_x;
      clear_seen    = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      alu_ctl.op    = ALU_NOP;
      alu_ctl.m     = m_cnt;
      load_rsp      = 1'b0;

      unique case (seq_ff)
         SEQ_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_op))
                  OP_DESIRED: pose_wr.des_en = agent_ok;
                  OP_CURRENT: pose_wr.cur_en = agent_ok;
                  OP_REACHED: reached_in     = req_reached;
                  OP_TICK: begin
                     unique case (phase_ff)
                        PH_WAIT: begin
                           if (all_seen) begin
                              phase_in = PH_CALC;
                           end
                        end
                        PH_CALC: begin
                           rd_en   = 1'b1;
                           rd_addr = IdxW'(cfg.own);
                           seq_in  = SEQ_OWN;
                        end
                        PH_GOING: begin
                           if (reached_ff) begin
                              phase_in = (below_z && below_x) ? PH_FINAL : PH_CALC;
                           end
                        end
                        PH_FINAL: begin
                           reached_in = 1'b0;
                           clear_seen = 1'b1;
                           alu_ctl.op = ALU_CLEAR;
                           phase_in   = PH_IDLE;
                           kind_in    = KIND_DONE;
                           seq_in     = SEQ_EMIT;
                        end
                        default: begin
                           // idle, and unused codes acting as idle
                           phase_in = (own_in_range && seen[IdxW'(cfg.own)]) ? PH_WAIT
                                                                             : PH_IDLE;
                        end
                     endcase
                  end
                  default: begin
                  end
               endcase
            end
         end
         SEQ_OWN: begin
            alu_ctl.op = ALU_LOAD_OWN;
            rd_en      = 1'b1;
            rd_addr    = '0;
            use_in     = own_cnt != '0;
            idx_in     = CntW'(1);
            seq_in     = SEQ_LOOP;
         end
         SEQ_LOOP: begin
            // read data is registered and arrives in the cycle after its address
            if (use_ff) begin
               alu_ctl.op = ALU_ACC;
            end
            if (idx_ff < n_eff) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff[IdxW-1:0];
               use_in  = idx_ff != own_cnt;
               idx_in  = idx_ff + CntW'(1);
            end else begin
               seq_in = SEQ_MQ;
            end
         end
         SEQ_MQ: begin
            alu_ctl.op = ALU_MUL_MQ;
            seq_in     = SEQ_SUM;
         end
         SEQ_SUM: begin
            alu_ctl.op = ALU_ADD_SUM;
            seq_in     = SEQ_GAIN;
         end
         SEQ_GAIN: begin
            alu_ctl.op = ALU_MUL_GAIN;
            seq_in     = SEQ_ROUND;
         end
         SEQ_ROUND: begin
            alu_ctl.op = ALU_ROUND;
            seq_in     = SEQ_TGT;
         end
         SEQ_TGT: begin
            alu_ctl.op = ALU_TARGET;
            kind_in    = KIND_TARGET;
            phase_in   = PH_GOING;
            seq_in     = SEQ_EMIT;
         end
         SEQ_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               seq_in   = SEQ_IDLE;
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         phase_ff     <= PH_IDLE;
         reached_ff   <= 1'b0;
         idx_ff       <= '0;
         use_ff       <= 1'b0;
         kind_ff      <= KIND_TARGET;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         reached_ff   <= reached_in;
         idx_ff       <= idx_in;
         use_ff       <= use_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_kind_ff <= kind_ff;
         rsp_z_ff    <= (kind_ff == KIND_DONE) ? '0 : target_z;
         rsp_x_ff    <= (kind_ff == KIND_DONE) ? '0 : target_x;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_target_z = rsp_z_ff;
   assign rsp_target_x = rsp_x_ff;

   `RCS_ASSERT_NXT(a_calc_starts, accept && req_op == OP_TICK && phase_ff == PH_CALC, seq_ff == SEQ_OWN, "compute tick did not start the own-pose load")
   `RCS_ASSERT_IMP(a_no_overwrite, rsp_valid_ff && !rsp_ready, !load_rsp, "pending result overwritten")
   `RCS_ASSERT_NXT(a_going_after_target, load_rsp && kind_ff == KIND_TARGET, phase_ff == PH_GOING, "target emitted outside going phase")
   `RCS_ASSERT_NXT(a_final_clears, accept && req_op == OP_TICK && phase_ff == PH_FINAL, phase_ff == PH_IDLE && !reached_ff && seq_ff == SEQ_EMIT, "final tick did not clear state")

endmodule

// File: src/rendezvous_consensus_sequencer_core.sv
// Top level of the rendezvous consensus sequencer: register port, pose
// store, two axis units and the sequencer. Depends on rcs_pkg and all rcs_ modules.
//
// Accepts desired poses, current poses, a target-reached flag and ticks, one
// transaction at a time. A tick in the compute phase runs the loop that reads
// one stored pose a cycle from the pose memory into each axis's shared adder,
// followed by the multiply, sum, gain, round and target steps and the emit
// step; the final tick goes straight to the emit step. A waiting result holds
// the block at its emit step until it is taken.
// Registers: own_index at 0x0, agent_count at 0x4, gain at 0x8 (Q1.16), threshold
// at 0xC (Q15.16); write them only while the block is idle.
module rendezvous_consensus_sequencer_core
   import rcs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [3:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_op,
   input  logic [AgentW-1:0]       req_agent,
   input  logic signed [PoseW-1:0] req_pos_z,
   input  logic signed [PoseW-1:0] req_pos_x,
   input  logic                    req_reached,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_kind,
   output logic signed [PoseW-1:0] rsp_target_z,
   output logic signed [PoseW-1:0] rsp_target_x
);

   logic [OwnW-1:0]   own_ff, own_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [GainW-1:0]  gain_ff, gain_in;
   logic [ThrW-1:0]   thr_ff, thr_in;
   logic              csr_wr;
   reg_idx_type       csr_idx;
   logic [GainW-1:0]  gain_eff;

   seq_cfg_type          cfg;
   pose_wr_type          pose_wr;
   pose_rd_type          pose_rd;
   logic                 clear_seen, rd_en;
   logic [IdxW-1:0]      rd_addr;
   logic [MaxAgents-1:0] seen;
   alu_ctl_type          alu_ctl;
   logic                 below_z, below_x;
   logic signed [PoseW-1:0] target_z, target_x;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = reg_idx_type'(paddr[3:2]);

   always_comb begin
      own_in   = own_ff;
      count_in = count_ff;
      gain_in  = gain_ff;
      thr_in   = thr_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_OWN:       own_in   = pwdata[OwnW-1:0];
            REG_COUNT:     count_in = pwdata[CountW-1:0];
            REG_GAIN:      gain_in  = pwdata[GainW-1:0];
            REG_THRESHOLD: thr_in   = pwdata[ThrW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff   <= '0;
         count_ff <= CountW'(1);
         gain_ff  <= GainW'(16384);
         thr_ff   <= ThrW'(98304);
      end else begin
         own_ff   <= own_in;
         count_ff <= count_in;
         gain_ff  <= gain_in;
         thr_ff   <= thr_in;
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_OWN:       prdata = 32'(own_ff);
         REG_COUNT:     prdata = 32'(count_ff);
         REG_GAIN:      prdata = 32'(gain_ff);
         REG_THRESHOLD: prdata = 32'(thr_ff);
         default:       prdata = '0;
      endcase
   end

   // gains above one act as one
   assign gain_eff  = (gain_ff > GainOne) ? GainOne : gain_ff;
   assign cfg.own   = own_ff;
   assign cfg.count = count_ff;

   rcs_pose_store u_store (
      .clock      (clock),
      .reset      (reset),
      .wr         (pose_wr),
      .clear_seen (clear_seen),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd         (pose_rd),
      .seen       (seen)
   );

   rcs_axis_unit u_axis_z (
      .clock     (clock),
      .reset     (reset),
      .ctl       (alu_ctl),
      .gain_eff  (gain_eff),
      .threshold (thr_ff),
      .rd_cur    (pose_rd.cur_z),
      .rd_des    (pose_rd.des_z),
      .below     (below_z),
      .target    (target_z)
   );

   rcs_axis_unit u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .ctl       (alu_ctl),
      .gain_eff  (gain_eff),
      .threshold (thr_ff),
      .rd_cur    (pose_rd.cur_x),
      .rd_des    (pose_rd.des_x),
      .below     (below_x),
      .target    (target_x)
   );

   rcs_sequencer u_seq (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_agent    (req_agent),
      .req_pos_z    (req_pos_z),
      .req_pos_x    (req_pos_x),
      .req_reached  (req_reached),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_target_z (rsp_target_z),
      .rsp_target_x (rsp_target_x),
      .pose_wr      (pose_wr),
      .clear_seen   (clear_seen),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .seen         (seen),
      .alu_ctl      (alu_ctl),
      .below_z      (below_z),
      .below_x      (below_x),
      .target_z     (target_z),
      .target_x     (target_x)
   );

endmodule
